// File: rtl/core/rmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB median filter package
// Shared widths, register indexes, control types and the window size function.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 3;

   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 13;
   localparam int RAD_W     = 2;
   localparam int PIX_W     = 8;
   localparam int RGB_W     = 3 * PIX_W;
   localparam int CNT_W     = 24;
   localparam int ROW_W     = 13;
   localparam int OFS_W     = 4;
   localparam int WINCNT_W  = 8;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_RADIUS = 2'd2
   } reg_index_type;

   // Control group from the sequencer to each selection unit.
   typedef struct packed {
      logic load;
      logic init;
      logic step;
   } sel_ctrl_type;

   // Number of pixels in a square window of the given radius.
   function automatic logic [WINCNT_W-1:0] win_count(input logic [RAD_W-1:0] sz);
      logic [WINCNT_W-1:0] side;
      begin
         side = WINCNT_W'(2 * sz + 1);
         return WINCNT_W'(side * side);
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/rmf_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one pixel or drain beat.
// ----------------------------------------------------------------------------
interface rmf_req_if;
   import rmf_pkg::*;

   logic             valid;
   logic             ready;
   logic             kind;
   logic [PIX_W-1:0] red_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] blue_in;

   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rmf_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one filtered pixel beat.
// ----------------------------------------------------------------------------
interface rmf_rsp_if;
   import rmf_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_out;
   logic [PIX_W-1:0] green_out;
   logic [PIX_W-1:0] blue_out;
   logic             frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rgb_median_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB median filter unit
// Streaming per-channel square median filter with edge replication.
// ----------------------------------------------------------------------------
// A beat that releases a result takes n reads of the single line store read
// port, n = (2*radius+1)^2, then the read pipeline, eight radix steps and one
// load, and the load waits while the previous result is still to be taken.
// Reset sets width 1024, height 1024, radius 3 and clears the counters; the
// line store is not cleared.
module rgb_median_filter_unit #(
   parameter int MAX_WIDTH  = rmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = rmf_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   rmf_req_if.sink                            req_bus,
   rmf_rsp_if.source                          rsp_bus,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [rmf_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [rmf_pkg::PDATA_W-1:0]   pwdata,
   output logic      [rmf_pkg::PDATA_W-1:0]   prdata,
   output logic                               pready
);
   import rmf_pkg::*;

   localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int KW    = $clog2(WIN);
   localparam int SW    = AW + 2;
   localparam int BW    = $clog2(PIX_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FLUSH,
      ST_SELECT,
      ST_OUT
   } state_type;

   state_type            state_ff;
   logic [WIDTH_W-1:0]   width_ff;
   logic [HEIGHT_W-1:0]  height_ff;
   logic [RAD_W-1:0]     radius_ff;
   logic [CNT_W-1:0]     taken_ff;
   logic [CNT_W-1:0]     given_ff;
   logic [WIDTH_W-1:0]   ocol_ff;
   logic [ROW_W-1:0]     orow_ff;
   logic [AW-1:0]        rowbase_ff;
   logic [AW-1:0]        waddr_ff;
   logic signed [OFS_W-1:0] dy_ff;
   logic signed [OFS_W-1:0] dx_ff;
   logic [KW-1:0]        k_ff;
   logic [BW-1:0]        bit_ff;
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     red_ff;
   logic [PIX_W-1:0]     green_ff;
   logic [PIX_W-1:0]     blue_ff;
   logic                 frame_end_ff;

   logic                 iss_vld_ff;
   logic [KW-1:0]        iss_k_ff;
   logic [AW-1:0]        addr_ff;
   logic                 dat_vld_ff;
   logic [KW-1:0]        dat_k_ff;

   logic [WIDTH_W-1:0]   eff_w;
   logic [HEIGHT_W-1:0]  eff_h;
   logic [RAD_W-1:0]     eff_r;
   logic [CNT_W-1:0]     total;
   logic [CNT_W:0]       need_raw;
   logic [CNT_W:0]       need;
   logic [CNT_W-1:0]     taken_inc;
   logic [CNT_W-1:0]     given_inc;
   logic [AW-1:0]        waddr_inc;
   logic [AW:0]          rowbase_sum;
   logic [AW-1:0]        rowbase_inc;
   logic                 frame_full;
   logic                 pending;
   logic                 accept;
   logic                 do_emit;
   logic                 wr_en;
   logic                 out_load;
   logic                 fetch_last;
   logic                 sel_init;
   logic [WINCNT_W-1:0]  win_n;
   logic [WINCNT_W-1:0]  rank;
   logic signed [OFS_W-1:0] r_pos;
   reg_index_type        cfg_idx;
   logic                 cfg_wr;

   logic signed [ROW_W+1:0]       row_sum;
   logic signed [ROW_W+1:0]       row_cl;
   logic signed [ROW_W+1:0]       row_delta;
   logic signed [WIDTH_W+1:0]     col_sum;
   logic [WIDTH_W-1:0]            cc;
   logic signed [OFS_W+WIDTH_W:0] prod;
   logic signed [SW-1:0]          addr_sum;
   logic signed [SW-1:0]          addr_adj;
   logic [AW-1:0]                 addr_n;

   logic [RGB_W-1:0]     rd_data;
   sel_ctrl_type         sel_ctrl;
   logic [PIX_W-1:0]     med_red;
   logic [PIX_W-1:0]     med_green;
   logic [PIX_W-1:0]     med_blue;

   // Effective configuration and frame bookkeeping.
   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) begin
         eff_w = WIDTH_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = WIDTH_W'(MAX_WIDTH);
      end
      eff_h = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      eff_r = radius_ff;
      if (radius_ff == '0) begin
         eff_r = RAD_W'(1);
      end else if (int'(radius_ff) > MAX_RADIUS) begin
         eff_r = RAD_W'(MAX_RADIUS);
      end
      total     = CNT_W'(eff_w) * CNT_W'(eff_h);
      taken_inc = taken_ff + CNT_W'(1);
      given_inc = given_ff + CNT_W'(1);
      need_raw  = (CNT_W+1)'(given_ff) + (CNT_W+1)'(CNT_W'(eff_r) * CNT_W'(eff_w))
                  + (CNT_W+1)'(eff_r) + (CNT_W+1)'(1);
      need      = (need_raw > (CNT_W+1)'(total)) ? (CNT_W+1)'(total) : need_raw;
      frame_full = (taken_ff >= total);
      pending    = (given_ff < total);
      win_n      = win_count(eff_r);
      rank       = win_n >> 1;
      r_pos      = OFS_W'(eff_r);
      waddr_inc  = (int'(waddr_ff) == DEPTH - 1) ? '0 : waddr_ff + AW'(1);
      rowbase_sum = (AW+1)'(rowbase_ff) + (AW+1)'(eff_w);
      rowbase_inc = (rowbase_sum >= (AW+1)'(DEPTH)) ? AW'(rowbase_sum - (AW+1)'(DEPTH))
                                                    : AW'(rowbase_sum);
   end

   assign accept   = req_bus.valid && (state_ff == ST_IDLE);
   assign wr_en    = accept && !req_bus.kind && !frame_full;
   assign do_emit  = accept && (req_bus.kind ? (frame_full && pending)
                     : (!frame_full && pending && ((CNT_W+1)'(taken_inc) >= need)));
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);
   assign fetch_last = (state_ff == ST_FETCH) && (k_ff == KW'(win_n - WINCNT_W'(1)));
   assign sel_init = (state_ff == ST_FLUSH) && !iss_vld_ff && !dat_vld_ff;

   // Window address: ring position of the clamped row and column.
   always_comb begin
      row_sum   = $signed({2'b00, orow_ff}) + (ROW_W+2)'(dy_ff);
      row_cl    = row_sum;
      if (row_sum < 0) begin
         row_cl = '0;
      end else if (row_sum > $signed({2'b00, eff_h - HEIGHT_W'(1)})) begin
         row_cl = $signed({2'b00, eff_h - HEIGHT_W'(1)});
      end
      row_delta = row_cl - $signed({2'b00, orow_ff});
      col_sum   = $signed({2'b00, ocol_ff}) + (WIDTH_W+2)'(dx_ff);
      cc        = WIDTH_W'(col_sum);
      if (col_sum < 0) begin
         cc = '0;
      end else if (col_sum > $signed({2'b00, eff_w - WIDTH_W'(1)})) begin
         cc = eff_w - WIDTH_W'(1);
      end
      prod     = $signed(OFS_W'(row_delta)) * $signed({1'b0, eff_w});
      addr_sum = $signed({2'b00, rowbase_ff}) + SW'(prod) + SW'($signed({1'b0, cc}));
      addr_adj = addr_sum;
      if (addr_sum < 0) begin
         addr_adj = addr_sum + SW'(DEPTH);
      end else if (addr_sum >= SW'(DEPTH)) begin
         addr_adj = addr_sum - SW'(DEPTH);
      end
      addr_n = AW'(addr_adj);
   end

   // Read pipeline: address register, then registered store data.
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_vld_ff <= 1'b0;
         dat_vld_ff <= 1'b0;
      end else begin
         iss_vld_ff <= (state_ff == ST_FETCH);
         dat_vld_ff <= iss_vld_ff;
      end
      iss_k_ff <= k_ff;
      addr_ff  <= addr_n;
      dat_k_ff <= iss_k_ff;
   end

   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = reg_index_type'(paddr[PADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_W'(1024);
         height_ff    <= HEIGHT_W'(1024);
         radius_ff    <= RAD_W'(3);
         taken_ff     <= '0;
         given_ff     <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         rowbase_ff   <= '0;
         waddr_ff     <= '0;
         dy_ff        <= '0;
         dx_ff        <= '0;
         k_ff         <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         frame_end_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (wr_en) begin
                  taken_ff <= taken_inc;
                  waddr_ff <= waddr_inc;
               end
               if (do_emit) begin
                  dy_ff    <= -r_pos;
                  dx_ff    <= -r_pos;
                  k_ff     <= '0;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               k_ff <= k_ff + KW'(1);
               if (dx_ff == r_pos) begin
                  dx_ff <= -r_pos;
                  dy_ff <= dy_ff + OFS_W'(1);
               end else begin
                  dx_ff <= dx_ff + OFS_W'(1);
               end
               if (fetch_last) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               if (sel_init) begin
                  bit_ff   <= '0;
                  state_ff <= ST_SELECT;
               end
            end
            ST_SELECT: begin
               bit_ff <= bit_ff + BW'(1);
               if (bit_ff == BW'(PIX_W - 1)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  red_ff       <= med_red;
                  green_ff     <= med_green;
                  blue_ff      <= med_blue;
                  frame_end_ff <= (given_inc == total);
                  state_ff     <= ST_IDLE;
                  if (given_inc >= total) begin
                     given_ff   <= '0;
                     taken_ff   <= '0;
                     ocol_ff    <= '0;
                     orow_ff    <= '0;
                     rowbase_ff <= '0;
                     waddr_ff   <= '0;
                  end else begin
                     given_ff <= given_inc;
                     if (ocol_ff == eff_w - WIDTH_W'(1)) begin
                        ocol_ff    <= '0;
                        orow_ff    <= orow_ff + ROW_W'(1);
                        rowbase_ff <= rowbase_inc;
                     end else begin
                        ocol_ff <= ocol_ff + WIDTH_W'(1);
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // A register write starts a new frame.
         if (cfg_wr) begin
            case (cfg_idx)
               REG_WIDTH:  width_ff  <= pwdata[WIDTH_W-1:0];
               REG_HEIGHT: height_ff <= pwdata[HEIGHT_W-1:0];
               REG_RADIUS: radius_ff <= pwdata[RAD_W-1:0];
               default: begin
               end
            endcase
            if (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT || cfg_idx == REG_RADIUS) begin
               given_ff   <= '0;
               taken_ff   <= '0;
               ocol_ff    <= '0;
               orow_ff    <= '0;
               rowbase_ff <= '0;
               waddr_ff   <= '0;
            end
         end
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_WIDTH:  prdata = PDATA_W'(width_ff);
         REG_HEIGHT: prdata = PDATA_W'(height_ff);
         REG_RADIUS: prdata = PDATA_W'(radius_ff);
         default:    prdata = '0;
      endcase
   end

   assign pready            = 1'b1;
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.red_out   = red_ff;
   assign rsp_bus.green_out = green_ff;
   assign rsp_bus.blue_out  = blue_ff;
   assign rsp_bus.frame_end = frame_end_ff;

   rmf_ram #(
      .WIDTH (RGB_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (waddr_ff),
      .wr_data ({req_bus.red_in, req_bus.green_in, req_bus.blue_in}),
      .rd_en   (iss_vld_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign sel_ctrl.load = dat_vld_ff;
   assign sel_ctrl.init = sel_init;
   assign sel_ctrl.step = (state_ff == ST_SELECT);

   rmf_median_select #(.WIN(WIN)) u_sel_red (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sel_ctrl),
      .load_idx (dat_k_ff),
      .load_val (rd_data[3*PIX_W-1:2*PIX_W]),
      .win_n    (win_n),
      .rank     (rank),
      .result   (med_red)
   );

   rmf_median_select #(.WIN(WIN)) u_sel_green (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sel_ctrl),
      .load_idx (dat_k_ff),
      .load_val (rd_data[2*PIX_W-1:PIX_W]),
      .win_n    (win_n),
      .rank     (rank),
      .result   (med_green)
   );

   rmf_median_select #(.WIN(WIN)) u_sel_blue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sel_ctrl),
      .load_idx (dat_k_ff),
      .load_val (rd_data[PIX_W-1:0]),
      .win_n    (win_n),
      .rank     (rank),
      .result   (med_blue)
   );

`ifndef ASSERT_OFF
   a_given_le_taken: assert property (@(posedge clock) disable iff (reset)
      given_ff <= taken_ff)
      else $error("more results given than pixels taken");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (int'(addr_n) < DEPTH))
      else $error("window address outside the line store");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (out_load && (given_inc == total) && !cfg_wr) |=> (given_ff == '0 && taken_ff == '0))
      else $error("counters not cleared after the last beat of the frame");
`endif
endmodule
`default_nettype wire

// File: rtl/core/rmf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 7168
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/rmf_median_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Median selection
// Bit-serial radix selection of one rank over the window of one channel.
// ----------------------------------------------------------------------------
module rmf_median_select #(
   parameter int WIN = 49
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rmf_pkg::sel_ctrl_type            ctrl,
   input  wire logic [$clog2(WIN)-1:0]           load_idx,
   input  wire logic [rmf_pkg::PIX_W-1:0]        load_val,
   input  wire logic [rmf_pkg::WINCNT_W-1:0]     win_n,
   input  wire logic [rmf_pkg::WINCNT_W-1:0]     rank,
   output logic      [rmf_pkg::PIX_W-1:0]        result
);
   import rmf_pkg::*;

   logic [PIX_W-1:0]    win_ff [WIN];
   logic [WIN-1:0]      active_ff;
   logic [WINCNT_W-1:0] rank_ff;
   logic [PIX_W-1:0]    res_ff;
   logic [WINCNT_W-1:0] zeros;
   logic                take_one;

   // Count the live candidates whose current top bit is clear.
   always_comb begin
      zeros = '0;
      for (int i = 0; i < WIN; i++) begin
         zeros = zeros + WINCNT_W'(active_ff[i] & ~win_ff[i][PIX_W-1]);
      end
      take_one = (rank_ff >= zeros);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (ctrl.init) begin
         for (int i = 0; i < WIN; i++) begin
            active_ff[i] <= (WINCNT_W'(i) < win_n);
         end
      end else if (ctrl.step) begin
         for (int i = 0; i < WIN; i++) begin
            active_ff[i] <= active_ff[i] & (win_ff[i][PIX_W-1] == take_one);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         win_ff[load_idx] <= load_val;
      end else if (ctrl.step) begin
         for (int i = 0; i < WIN; i++) begin
            win_ff[i] <= {win_ff[i][PIX_W-2:0], 1'b0};
         end
      end
      if (ctrl.init) begin
         rank_ff <= rank;
      end else if (ctrl.step) begin
         if (take_one) begin
            rank_ff <= rank_ff - zeros;
         end
         res_ff <= {res_ff[PIX_W-2:0], take_one};
      end
   end

   assign result = res_ff;

`ifndef ASSERT_OFF
   a_rank_live: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> ($countones(active_ff) > rank_ff))
      else $error("selection rank lies beyond the live candidates");

   a_shrink: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> ($countones(active_ff) <= $past($countones(active_ff))))
      else $error("candidate set grew during selection");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      ctrl.init |-> (!ctrl.step && !ctrl.load))
      else $error("selection started while the window was still changing");
`endif
endmodule
`default_nettype wire

// File: tb/rgb_median_filter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB median filter unit test
// Streams small RGB frames through the filter under random sender gaps and
// receiver stalls. A behavioural model tracks the line store and frame
// counters and predicts every filtered pixel, which is compared per channel.
// ----------------------------------------------------------------------------
module rgb_median_filter_unit_test;
   import rmf_pkg::*;

   localparam int STORE_DEPTH = (2 * MAX_RADIUS_DEF + 1) * MAX_WIDTH_DEF;
   localparam int SETTLE      = 80;
   localparam int STALL_LIMIT = 6000;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_end;
   } filtered_pixel_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   rmf_req_if req ();
   rmf_rsp_if rsp ();

   rgb_median_filter_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Model state
   logic [RGB_W-1:0]    line_store [STORE_DEPTH];
   int unsigned         pixels_taken, pixels_given;
   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;
   logic [RAD_W-1:0]    radius_reg;
   filtered_pixel_type  pending_pixels [$];

   int  error_count;
   int  beats_sent;
   int  idle_cycles;
   bit  calm;
   bit  rsp_taken;
   int  rsp_hold;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   task automatic report(input string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic int unsigned eff_radius();
      return (radius_reg == 0) ? 1 : radius_reg;
   endfunction

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Median of the window centred on the next output pixel, per channel.
   function automatic filtered_pixel_type next_filtered(input int unsigned total);
      int unsigned        w, h, r, rank, cum;
      int                 row, col, rr, cc;
      int                 hist [3][256];
      logic [RGB_W-1:0]   px;
      filtered_pixel_type res;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      row = pixels_given / w;
      col = pixels_given % w;
      rank = ((2 * r + 1) * (2 * r + 1)) / 2;
      foreach (hist[c, v]) hist[c][v] = 0;
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
         rr = clamp(row + dy, 0, h - 1);
         for (int dx = -int'(r); dx <= int'(r); dx++) begin
            cc = clamp(col + dx, 0, w - 1);
            px = line_store[(rr * w + cc) % STORE_DEPTH];
            hist[0][px[23:16]]++;
            hist[1][px[15:8]]++;
            hist[2][px[7:0]]++;
         end
      end
      for (int c = 0; c < 3; c++) begin
         cum = 0;
         for (int v = 0; v < 256; v++) begin
            cum += hist[c][v];
            if (cum > rank) begin
               if (c == 0) res.red = PIX_W'(v);
               else if (c == 1) res.green = PIX_W'(v);
               else res.blue = PIX_W'(v);
               break;
            end
         end
      end
      res.frame_end = (pixels_given + 1 == total);
      pixels_given++;
      if (pixels_given >= total) begin
         pixels_given = 0;
         pixels_taken = 0;
      end
      return res;
   endfunction

   // Updates the model for one accepted beat and queues its result, if any.
   task automatic predict_beat(input logic kind, input logic [RGB_W-1:0] rgb);
      int unsigned w, r, total, need;
      w = eff_width();
      r = eff_radius();
      total = w * eff_height();
      if (kind == 1'b0) begin
         if (pixels_taken >= total) return;
         line_store[pixels_taken % STORE_DEPTH] = rgb;
         pixels_taken++;
         need = pixels_given + r * w + r + 1;
         if (need > total) need = total;
         if (pixels_given < total && pixels_taken >= need)
            pending_pixels.push_back(next_filtered(total));
      end else if (pixels_taken >= total && pixels_given < total) begin
         pending_pixels.push_back(next_filtered(total));
      end
   endtask

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // Sends one beat; valid stays high afterwards unless the next call gaps.
   task automatic send_beat(input logic kind, input logic [RGB_W-1:0] rgb);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid    <= 1'b1;
      req.kind     <= kind;
      req.red_in   <= rgb[23:16];
      req.green_in <= rgb[15:8];
      req.blue_in  <= rgb[7:0];
      do @(posedge clock); while (!req.ready);
      idle_cycles = 0;
      beats_sent++;
      predict_beat(kind, rgb);
   endtask

   function automatic logic [RGB_W-1:0] random_rgb();
      logic [RGB_W-1:0] v;
      v = RGB_W'($urandom);
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         default: ;
      endcase
      return v;
   endfunction

   task automatic await_results();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [PDATA_W-1:0] value);
      await_results();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= PADDR_W'(4 * idx);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      idle_cycles = 0;
      case (idx)
         REG_WIDTH:  width_reg  = value[WIDTH_W-1:0];
         REG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
         REG_RADIUS: radius_reg = value[RAD_W-1:0];
         default: ;
      endcase
      pixels_taken = 0;
      pixels_given = 0;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_geometry(input int w, input int h, input int r);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_RADIUS, r);
   endtask

   // One frame of pixels with optional stray beats, then drains to the end once the frame is full.
   task automatic run_frame(input int pixels, input int noise_pct, input bit pause_once);
      int unsigned total;
      int          pause_at;
      total = eff_width() * eff_height();
      pause_at = $urandom_range(0, pixels);
      for (int i = 0; i < pixels; i++) begin
         if ($urandom_range(0, 99) < noise_pct) send_beat(1'b1, random_rgb());
         if (pause_once && i == pause_at) await_results();
         send_beat(1'b0, random_rgb());
      end
      if (pixels >= total) begin
         if ($urandom_range(0, 99) < noise_pct) send_beat(1'b0, random_rgb());
         while (pixels_taken != 0) send_beat(1'b1, random_rgb());
         if ($urandom_range(0, 99) < noise_pct) send_beat(1'b1, random_rgb());
      end
   endtask

   task automatic test_directed();
      set_geometry(3, 2, 1);
      send_beat(1'b0, 24'h000000);
      send_beat(1'b1, 24'hFFFFFF);        // drain before the frame is in
      send_beat(1'b0, 24'hFFFFFF);
      send_beat(1'b0, 24'hFF00FF);
      send_beat(1'b0, 24'h00FF00);
      send_beat(1'b0, 24'h808080);
      send_beat(1'b0, 24'h7F7F7F);
      send_beat(1'b0, 24'h123456);        // frame already full: ignored
      repeat (4) send_beat(1'b1, 24'h0);
      send_beat(1'b1, 24'h0);             // nothing left to drain
      set_geometry(0, 0, 0);              // all act as their minimum
      run_frame(1, 0, 0);
   endtask

   task automatic test_extremes();
      calm = 1'b1;
      set_geometry(2047, 2, 1);           // width saturates at the maximum
      run_frame(MAX_WIDTH_DEF + 40, 0, 0);
      calm = 1'b0;
      set_geometry(1, 4096, 2);           // tall frame, abandoned part way
      run_frame(40, 5, 0);
      set_geometry(5, 3, 3);              // window larger than the image
      run_frame(15, 10, 1);
   endtask

   task automatic test_random_frames();
      int w, h;
      while (beats_sent < 1700) begin
         calm = ($urandom_range(0, 4) == 0);
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
         h = $urandom_range(1, 9);
         set_geometry(w, h, $urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) run_frame($urandom_range(0, w * h), 10, 1);
         else run_frame(w * h, $urandom_range(0, 15), $urandom_range(0, 3) == 0);
      end
   endtask

   // Result side: stall per beat, compare against the oldest prediction.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_hold = draw_wait();
            rsp_taken = 1'b0;
         end
         if (rsp_hold > 0) begin
            rsp.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      filtered_pixel_type exp_px;
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_taken = 1'b1;
         idle_cycles = 0;
         if (pending_pixels.size() == 0) begin
            report("result beat with no prediction outstanding");
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp.red_out !== exp_px.red)
               report($sformatf("red %0d, expected %0d", rsp.red_out, exp_px.red));
            if (rsp.green_out !== exp_px.green)
               report($sformatf("green %0d, expected %0d", rsp.green_out, exp_px.green));
            if (rsp.blue_out !== exp_px.blue)
               report($sformatf("blue %0d, expected %0d", rsp.blue_out, exp_px.blue));
            if (rsp.frame_end !== exp_px.frame_end)
               report($sformatf("frame_end %0b, expected %0b",
                                rsp.frame_end, exp_px.frame_end));
         end
      end
   end

   always @(posedge clock) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("rgb_median_filter_unit_test: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req.valid = 1'b0;
      req.kind = 1'b0;
      req.red_in = '0;
      req.green_in = '0;
      req.blue_in = '0;
      rsp.ready = 1'b0;
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      radius_reg = 2'd3;
      pixels_taken = 0;
      pixels_given = 0;
      error_count = 0;
      beats_sent = 0;
      idle_cycles = 0;
      calm = 1'b0;
      rsp_taken = 1'b0;
      rsp_hold = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_extremes();
      test_random_frames();

      await_results();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("rgb_median_filter_unit_test: clean");
      end else begin
         $display("rgb_median_filter_unit_test: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/rmf_pkg.sv
rtl/core/rmf_req_if.sv
rtl/core/rmf_rsp_if.sv
rtl/core/rmf_ram.sv
rtl/core/rmf_median_select.sv
rtl/core/rgb_median_filter_unit.sv
tb/rgb_median_filter_unit_test.sv
